// File: sv/ipv4c_pkg.sv
package ipv4c_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [3:0] MIN_IHL = 4'd5;

  localparam logic [1:0] HANDLER_DROP = 2'd0;
  localparam logic [1:0] HANDLER_TCP  = 2'd1;
  localparam logic [1:0] HANDLER_UDP  = 2'd2;

  // byte offsets within the fixed part of the header
  localparam logic [5:0] OFS_VER_IHL = 6'd0;
  localparam logic [5:0] OFS_LEN_HI  = 6'd2;
  localparam logic [5:0] OFS_LEN_LO  = 6'd3;
  localparam logic [5:0] OFS_TTL     = 6'd8;
  localparam logic [5:0] OFS_PROTO   = 6'd9;
  localparam logic [5:0] OFS_SRC_LO  = 6'd12;
  localparam logic [5:0] OFS_SRC_HI  = 6'd15;
  localparam logic [5:0] OFS_DST_LO  = 6'd16;
  localparam logic [5:0] OFS_DST_HI  = 6'd19;

  typedef struct packed {
    logic [3:0]  ihl;
    logic [15:0] tot_length;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_fields_t;

endpackage

// File: sv/ipv4_rx_header_classifier_unit.sv
// IPv4 receive header classifier. Header bytes enter one per transfer in network order,
// with first_byte set on byte 0; a full input rate of one byte per clock is sustained
// while the result side keeps taking results. Each byte passes an input register, then
// field capture and classification into the result register, which takes the verdict
// from the last header byte (IHL*4 bytes, IHL below 5 taken as 5). Option bytes are
// consumed without effect, bytes outside a header are dropped, and a new first_byte
// abandons a header in progress with no result. The verdict is drop on zero TTL or a
// destination other than local_ip, else TCP, UDP or drop by protocol; addresses and
// lengths are reported for dropped headers too. local_ip is to be written through
// cfg_we/cfg_wdata only while no header is in flight; the block does not enforce this.
module ipv4_rx_header_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  handler,
  output logic [31:0] source_ip,
  output logic [31:0] dest_ip,
  output logic [5:0]  hdr_bytes,
  output logic [15:0] payload_len
);
  import ipv4c_pkg::*;

  logic [31:0] local_ip;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_first;
  logic        advance;

  hdr_fields_t fields_next;
  logic        done;
  logic [1:0]  handler_next;
  logic [5:0]  hdr_bytes_next;
  logic [15:0] payload_len_next;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= 32'd0;
    end else if (cfg_we) begin
      local_ip <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte  <= data_byte;
      stage_first <= first_byte;
    end
  end

  ipv4c_fields u_fields (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .data_byte   (stage_byte),
    .first_byte  (stage_first),
    .fields_next (fields_next),
    .done        (done)
  );

  ipv4c_verdict u_verdict (
    .fields      (fields_next),
    .local_ip    (local_ip),
    .handler     (handler_next),
    .hdr_bytes   (hdr_bytes_next),
    .payload_len (payload_len_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      handler     <= handler_next;
      source_ip   <= fields_next.src;
      dest_ip     <= fields_next.dst;
      hdr_bytes   <= hdr_bytes_next;
      payload_len <= payload_len_next;
    end
  end

  // a delivered header must have been addressed to us
  a_deliver_local: assert property (@(posedge clk) disable iff (rst)
    out_valid && (handler != HANDLER_DROP) |-> dest_ip == local_ip)
    else $error("delivered header with foreign destination");

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hdr_bytes >= 6'd20) && (hdr_bytes[1:0] == 2'b00))
    else $error("header length out of range");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");

  a_handler_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (handler == HANDLER_DROP) || (handler == HANDLER_TCP)
                  || (handler == HANDLER_UDP))
    else $error("invalid handler code");

endmodule

// File: sv/ipv4c_fields.sv
module ipv4c_fields (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  output ipv4c_pkg::hdr_fields_t fields_next,
  output logic                   done
);
  import ipv4c_pkg::*;

  logic [5:0]  byte_count;
  logic        in_header;
  hdr_fields_t fields;

  logic        active;
  logic [5:0]  idx;
  logic [5:0]  idx_inc;
  logic [5:0]  hdr_len;
  logic        last;

  always_comb begin
    active      = first_byte | in_header;
    idx         = first_byte ? 6'd0 : byte_count;
    idx_inc     = idx + 6'd1;
    fields_next = fields;
    case (idx) inside
      OFS_VER_IHL: begin
        fields_next.ihl = (data_byte[3:0] < MIN_IHL) ? MIN_IHL : data_byte[3:0];
      end
      OFS_LEN_HI:  fields_next.tot_length[15:8] = data_byte;
      OFS_LEN_LO:  fields_next.tot_length[7:0]  = data_byte;
      OFS_TTL:     fields_next.ttl   = data_byte;
      OFS_PROTO:   fields_next.proto = data_byte;
      [OFS_SRC_LO:OFS_SRC_HI]: fields_next.src = {fields.src[23:0], data_byte};
      [OFS_DST_LO:OFS_DST_HI]: fields_next.dst = {fields.dst[23:0], data_byte};
      default: ;
    endcase
    hdr_len = {fields_next.ihl, 2'b00};
    last    = !(idx_inc < hdr_len);
    done    = en & active & last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header  <= 1'b0;
      byte_count <= 6'd0;
    end else if (en && active) begin
      if (last) begin
        in_header  <= 1'b0;
        byte_count <= 6'd0;
      end else begin
        in_header  <= 1'b1;
        byte_count <= idx_inc;
      end
    end
  end

  // captured fields carry no reset: each is written before a verdict reads it
  always_ff @(posedge clk) begin
    if (en && active) begin
      fields <= fields_next;
    end
  end

endmodule

// File: sv/ipv4c_verdict.sv
module ipv4c_verdict (
  input  ipv4c_pkg::hdr_fields_t fields,
  input  logic [31:0]            local_ip,
  output logic [1:0]             handler,
  output logic [5:0]             hdr_bytes,
  output logic [15:0]            payload_len
);
  import ipv4c_pkg::*;

  logic [15:0] hdr_wide;

  always_comb begin
    hdr_bytes = {fields.ihl, 2'b00};
    hdr_wide  = {10'd0, hdr_bytes};
    // saturate at zero when total length is shorter than the header
    payload_len = (fields.tot_length >= hdr_wide) ? (fields.tot_length - hdr_wide) : 16'd0;

    if (fields.ttl == 8'd0) begin
      handler = HANDLER_DROP;
    end else if (fields.dst != local_ip) begin
      handler = HANDLER_DROP;
    end else if (fields.proto == PROTO_TCP) begin
      handler = HANDLER_TCP;
    end else if (fields.proto == PROTO_UDP) begin
      handler = HANDLER_UDP;
    end else begin
      handler = HANDLER_DROP;
    end
  end

endmodule
